@@ design/asbd_pkg.sv @@
// Shared types, widths and helpers for the superblock deinterleave address generator.
`timescale 1ns / 1ps
`default_nettype none

package asbd_pkg;

  // Field and register widths
  localparam int DATA_W     = 8;
  localparam int ADDR_W     = 16;
  localparam int MODE_W     = 2;
  localparam int H_W        = 7;
  localparam int SIZE_W     = 13;
  localparam int Y_W        = 6;
  localparam int CNT_W      = 12;
  localparam int CPS_W      = 13;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  // Effective limits of the size registers
  localparam logic [H_W-1:0]    H_MAX    = 7'd64;
  localparam logic [SIZE_W-1:0] SIZE_MAX = 13'd4096;

  // Shared multiplier operand and product widths
  localparam int MUL_A_W = 14;
  localparam int MUL_B_W = 20;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int SUM_W   = PROD_W + 1;

  localparam int DEFAULT_MAX_SUPERBLOCK_BYTES = 65536;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INTERLEAVE_MODE      = 3'd0,
    REG_SUBPACKETS_PER_BLOCK = 3'd1,
    REG_FRAME_BYTES          = 3'd2,
    REG_CODED_FRAME_BYTES    = 3'd3,
    REG_CHUNK_BYTES          = 3'd4
  } cfg_reg_t;

  // Interleave modes
  typedef enum logic [MODE_W-1:0] {
    MODE_CHUNKED = 2'd0,
    MODE_SUBPKT  = 2'd1,
    MODE_WHOLE   = 2'd2,
    MODE_MUTED   = 2'd3
  } mode_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SETUP,
    S_DIV_WAIT,
    S_MUL_A,
    S_MUL_B,
    S_FIN
  } state_t;

  // Zero reads as one, values above the maximum saturate
  function automatic logic [H_W-1:0] clamp_h(input logic [H_W-1:0] v);
    logic [H_W-1:0] r;
    if (v == '0) r = H_W'(1);
    else if (v > H_MAX) r = H_MAX;
    else r = v;
    return r;
  endfunction

  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
    logic [SIZE_W-1:0] r;
    if (v == '0) r = SIZE_W'(1);
    else if (v > SIZE_MAX) r = SIZE_MAX;
    else r = v;
    return r;
  endfunction

endpackage

`default_nettype wire

@@ design/asbd_if.sv @@
// Handshake channel interfaces: input bytes, result items and configuration writes.
`timescale 1ns / 1ps
`default_nettype none

interface asbd_in_if;
  import asbd_pkg::*;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] data_byte;
  logic              packet_start;
  logic              key_flag;

  modport source (output valid, data_byte, packet_start, key_flag, input ready);
  modport sink (input valid, data_byte, packet_start, key_flag, output ready);
endinterface

interface asbd_out_if;
  import asbd_pkg::*;
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] write_address;
  logic [DATA_W-1:0] write_data;
  logic              write_valid;
  logic              subpacket_done;
  logic              superblock_done;

  modport source (output valid, write_address, write_data, write_valid, subpacket_done,
                  superblock_done, input ready);
  modport sink (input valid, write_address, write_data, write_valid, subpacket_done,
                superblock_done, output ready);
endinterface

interface asbd_cfg_if;
  import asbd_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] wdata;

  modport source (output valid, index, wdata, input ready);
  modport sink (input valid, index, wdata, output ready);
endinterface

`default_nettype wire

@@ design/asbd_mul.sv @@
// Shared multiplier with a registered product.
`timescale 1ns / 1ps
`default_nettype none

module asbd_mul
  import asbd_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic [MUL_A_W-1:0] a,
  input  wire logic [MUL_B_W-1:0] b,
  output logic      [PROD_W-1:0]  p
);

  // Capture the product when a pass is issued, hold otherwise
  always_ff @(posedge clk) begin
    if (en) begin
      p <= PROD_W'(a) * PROD_W'(b);
    end
  end

endmodule

`default_nettype wire

@@ design/asbd_div.sv @@
// Restoring divider, one quotient bit per cycle, for the chunk count of a subpacket.
`timescale 1ns / 1ps
`default_nettype none

module asbd_div
  import asbd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [SIZE_W-1:0] dividend,
  input  wire logic [SIZE_W-1:0] divisor,
  output logic                   busy,
  output logic      [SIZE_W-1:0] quotient
);

  localparam int STEP_W = $clog2(SIZE_W + 1);

  logic [STEP_W-1:0] steps;
  logic [SIZE_W:0]   rem;
  logic [SIZE_W-1:0] dsr;
  logic [SIZE_W:0]   shifted;
  logic              fits;

  assign busy    = (steps != '0);
  assign shifted = {rem[SIZE_W-1:0], quotient[SIZE_W-1]};
  assign fits    = (shifted >= {1'b0, dsr});

  // Step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= '0;
    end else if (start) begin
      steps <= STEP_W'(SIZE_W);
    end else if (busy) begin
      steps <= steps - STEP_W'(1);
    end
  end

  // Shift in one dividend bit, subtract where it fits
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dsr      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= fits ? (shifted - {1'b0, dsr}) : shifted;
      quotient <= {quotient[SIZE_W-2:0], fits};
    end
  end

endmodule

`default_nettype wire

@@ design/audio_superblock_deinterleave_addr.sv @@
// Top level: superblock deinterleave address generator with its sequencer.
`timescale 1ns / 1ps
`default_nettype none

// Takes one payload byte per request and returns its write address in the
// superblock buffer, the byte itself, a write-valid flag and the subpacket and
// superblock done flags. Each byte takes the sequencer through an accept step,
// two passes through the shared 14x20 multiplier and a finish step, where its
// result is loaded into an output register. The result waits there until taken;
// the finish step stalls while that register still holds an untaken result, and
// the next byte is accepted once the previous result has been loaded. After
// reset and after every configuration write the block runs a setup (an idle
// step to start it, then frame size over chunk size in a one-bit-per-cycle
// divider and the buffer limit on the multiplier) during which no byte is
// accepted. Configuration writes are taken while the sequencer is idle.

module audio_superblock_deinterleave_addr
  import asbd_pkg::*;
#(
  parameter int MAX_SUPERBLOCK_BYTES = DEFAULT_MAX_SUPERBLOCK_BYTES
) (
  input wire logic   clk,
  input wire logic   rst,
  asbd_in_if.sink    payload,
  asbd_out_if.source result,
  asbd_cfg_if.sink   cfg
);

  localparam int LIM_W = $clog2(MAX_SUPERBLOCK_BYTES + 1);

  state_t state, state_next;

  // Configuration registers
  logic [MODE_W-1:0] mode_reg;
  logic [H_W-1:0]    h_reg;
  logic [SIZE_W-1:0] w_reg;
  logic [SIZE_W-1:0] cfs_reg;
  logic [SIZE_W-1:0] sps_reg;
  logic              dirty;

  // Effective values
  mode_t             mode;
  logic [H_W-1:0]    h_e;
  logic [SIZE_W-1:0] w_e;
  logic [SIZE_W-1:0] cfs_e;
  logic [SIZE_W-1:0] sps_e;
  logic [Y_W-1:0]    half_h;
  logic [SIZE_W-1:0] csize;

  // Derived at setup
  logic [CPS_W-1:0] cps;
  logic [LIM_W-1:0] limit;

  // Counters and latched byte
  logic [Y_W-1:0]    y;
  logic [CNT_W-1:0]  x;
  logic [CNT_W-1:0]  b;
  logic [DATA_W-1:0] data;
  logic              empty;
  logic [PROD_W-1:0] a_reg;

  // Shared units
  logic               mul_en;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [PROD_W-1:0]  mul_p;
  logic               div_start;
  logic               div_busy;
  logic [SIZE_W-1:0]  div_q;

  logic in_take;
  logic cfg_take;
  logic out_free;

  // Counter adjust at accept
  logic [Y_W-1:0]   y0;
  logic [Y_W-1:0]   y1;
  logic [CNT_W-1:0] x0;
  logic [CNT_W-1:0] b0;
  logic             stale;

  // Finish step
  logic [SUM_W-1:0]  addr;
  logic              wr_ok;
  logic [CNT_W:0]    b_inc;
  logic [CNT_W:0]    x_inc;
  logic [Y_W:0]      y_inc;
  logic              sp_done;
  logic              sb_done;
  logic [Y_W-1:0]    y_fin;
  logic [CNT_W-1:0]  x_fin;
  logic [CNT_W-1:0]  b_fin;
  logic [PROD_W-1:0] lim_prod;

  assign mode   = mode_t'(mode_reg);
  assign h_e    = clamp_h(h_reg);
  assign w_e    = clamp_size(w_reg);
  assign cfs_e  = clamp_size(cfs_reg);
  assign sps_e  = clamp_size(sps_reg);
  assign half_h = Y_W'((H_W + 1)'(h_e) + (H_W + 1)'(1) >> 1);

  // Chunk size per mode
  always_comb begin
    unique case (mode)
      MODE_CHUNKED: csize = cfs_e;
      MODE_SUBPKT:  csize = sps_e;
      default:      csize = w_e;
    endcase
  end

  assign in_take  = payload.valid && payload.ready;
  assign cfg_take = cfg.valid && cfg.ready;
  assign out_free = !result.valid || result.ready;

  assign payload.ready = (state == S_IDLE) && !dirty && !cfg.valid;
  assign cfg.ready     = (state == S_IDLE);

  asbd_mul u_mul (
    .clk (clk),
    .en  (mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  asbd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (w_e),
    .divisor  (sps_e),
    .busy     (div_busy),
    .quotient (div_q)
  );

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg <= MODE_CHUNKED;
      h_reg    <= H_W'(1);
      w_reg    <= SIZE_W'(1);
      cfs_reg  <= SIZE_W'(1);
      sps_reg  <= SIZE_W'(1);
    end else if (cfg_take) begin
      unique case (cfg.index)
        REG_INTERLEAVE_MODE:      mode_reg <= cfg.wdata[MODE_W-1:0];
        REG_SUBPACKETS_PER_BLOCK: h_reg    <= cfg.wdata[H_W-1:0];
        REG_FRAME_BYTES:          w_reg    <= cfg.wdata;
        REG_CODED_FRAME_BYTES:    cfs_reg  <= cfg.wdata;
        REG_CHUNK_BYTES:          sps_reg  <= cfg.wdata;
        default: ;
      endcase
    end
  end

  // Sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and shared unit operands
  always_comb begin
    state_next = state;
    mul_en     = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    div_start  = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (dirty && !cfg.valid) begin
          state_next = S_SETUP;
        end else if (in_take) begin
          state_next = S_MUL_A;
        end
      end
      S_SETUP: begin
        // buffer size on the multiplier, chunk count on the divider
        mul_en     = 1'b1;
        mul_a      = MUL_A_W'(w_e);
        mul_b      = MUL_B_W'(h_e);
        div_start  = 1'b1;
        state_next = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (!div_busy) begin
          state_next = S_IDLE;
        end
      end
      S_MUL_A: begin
        mul_en = 1'b1;
        unique case (mode)
          MODE_CHUNKED: begin
            mul_a = {w_e, 1'b0};
            mul_b = MUL_B_W'(x);
          end
          MODE_SUBPKT: begin
            mul_a = MUL_A_W'(h_e);
            mul_b = MUL_B_W'(x);
          end
          default: begin
            mul_a = MUL_A_W'(w_e);
            mul_b = MUL_B_W'(y);
          end
        endcase
        state_next = S_MUL_B;
      end
      S_MUL_B: begin
        mul_en = 1'b1;
        unique case (mode)
          MODE_CHUNKED: begin
            mul_a = MUL_A_W'(cfs_e);
            mul_b = MUL_B_W'(y);
          end
          MODE_SUBPKT: begin
            mul_a = MUL_A_W'(sps_e);
            mul_b = mul_p[MUL_B_W-1:0] + (y[0] ? MUL_B_W'(half_h) : '0)
                    + MUL_B_W'(y >> 1);
          end
          default: begin
            mul_a = '0;
            mul_b = '0;
          end
        endcase
        state_next = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Setup bookkeeping
  assign lim_prod = (mul_p > PROD_W'(MAX_SUPERBLOCK_BYTES)) ?
                    PROD_W'(MAX_SUPERBLOCK_BYTES) : mul_p;

  always_ff @(posedge clk) begin
    if (rst) begin
      dirty <= 1'b1;
      cps   <= '0;
      limit <= '0;
    end else begin
      if (cfg_take) begin
        dirty <= 1'b1;
      end else if (state == S_DIV_WAIT && !div_busy) begin
        dirty <= 1'b0;
        limit <= lim_prod[LIM_W-1:0];
        unique case (mode)
          MODE_CHUNKED: cps <= CPS_W'(h_e >> 1);
          MODE_SUBPKT:  cps <= div_q;
          default:      cps <= CPS_W'(1);
        endcase
      end
    end
  end

  // Packet start and stale counter handling at accept
  always_comb begin
    y0    = (payload.packet_start && payload.key_flag) ? '0 : y;
    x0    = payload.packet_start ? '0 : x;
    b0    = payload.packet_start ? '0 : b;
    y1    = ({1'b0, y0} >= h_e) ? '0 : y0;
    stale = ({1'b0, x0} >= cps) || ({1'b0, b0} >= csize);
  end

  // Address, flags and counter advance in the finish step
  always_comb begin
    unique case (mode)
      MODE_CHUNKED: addr = SUM_W'(a_reg) + SUM_W'(mul_p) + SUM_W'(b);
      MODE_SUBPKT:  addr = SUM_W'(mul_p) + SUM_W'(b);
      default:      addr = SUM_W'(a_reg) + SUM_W'(b);
    endcase
    wr_ok   = !empty && (mode != MODE_MUTED) && (addr < SUM_W'(limit));
    b_inc   = {1'b0, b} + (CNT_W + 1)'(1);
    x_inc   = {1'b0, x} + (CNT_W + 1)'(1);
    y_inc   = {1'b0, y} + (Y_W + 1)'(1);
    sp_done = empty;
    b_fin   = b;
    x_fin   = x;
    if (!empty) begin
      if (b_inc >= csize) begin
        b_fin = '0;
        if (x_inc >= cps) begin
          x_fin   = '0;
          sp_done = 1'b1;
        end else begin
          x_fin = x_inc[CNT_W-1:0];
        end
      end else begin
        b_fin = b_inc[CNT_W-1:0];
      end
    end
    sb_done = sp_done && (y_inc >= h_e);
    y_fin   = sp_done ? (sb_done ? '0 : y_inc[Y_W-1:0]) : y;
  end

  // Counters
  always_ff @(posedge clk) begin
    if (rst) begin
      y <= '0;
      x <= '0;
      b <= '0;
    end else if (in_take) begin
      y <= y1;
      x <= stale ? '0 : x0;
      b <= stale ? '0 : b0;
    end else if (state == S_FIN && out_free) begin
      y <= y_fin;
      x <= x_fin;
      b <= b_fin;
    end
  end

  // Latch the byte and keep the first product
  always_ff @(posedge clk) begin
    if (in_take) begin
      data  <= payload.data_byte;
      empty <= (cps == '0);
    end
    if (state == S_MUL_B) begin
      a_reg <= mul_p;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (state == S_FIN && out_free) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FIN && out_free) begin
      result.write_address   <= wr_ok ? addr[ADDR_W-1:0] : '0;
      result.write_data      <= data;
      result.write_valid     <= wr_ok;
      result.subpacket_done  <= sp_done;
      result.superblock_done <= sb_done;
    end
  end

  // Checks
  a_sb_implies_sp: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (!result.superblock_done || result.subpacket_done))
    else $error("superblock done without subpacket done");

  a_suppressed_zero: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.write_valid) |-> (result.write_address == '0))
    else $error("suppressed write carries a nonzero address");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    in_take |=> (state == S_MUL_A))
    else $error("accepted request did not start the multiplier passes");

  a_cfg_marks_dirty: assert property (@(posedge clk) disable iff (rst)
    cfg_take |=> (dirty && !payload.ready))
    else $error("configuration write did not block requests until setup");

endmodule

`default_nettype wire

@@ tb/sv/audio_superblock_deinterleave_addr_tb.sv @@
// Self-checking testbench for the superblock deinterleave address generator.
`timescale 1ns / 1ps

module audio_superblock_deinterleave_addr_tb;
  import asbd_pkg::*;

  localparam int unsigned SB_LIMIT   = DEFAULT_MAX_SUPERBLOCK_BYTES;
  localparam int unsigned RAND_BYTES = 550;
  localparam int unsigned MAX_BURST  = 40;
  localparam int unsigned TAIL_CYC   = 40;

  // One payload byte request and one buffer write request
  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic              start;
    logic              key;
  } byte_req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
    logic              wr_valid;
    logic              sp_done;
    logic              sb_done;
  } write_req_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  asbd_in_if  in_ch ();
  asbd_out_if out_ch ();
  asbd_cfg_if cfg_ch ();

  audio_superblock_deinterleave_addr i_dut (
    .clk     (clk),
    .rst     (rst),
    .payload (in_ch),
    .result  (out_ch),
    .cfg     (cfg_ch)
  );

  always #4 clk = ~clk;

  // Shadow registers and counters of the address generator
  mode_t               mode_reg  = MODE_CHUNKED;
  logic [H_W-1:0]      h_reg     = 7'd1;
  logic [SIZE_W-1:0]   w_reg     = 13'd1;
  logic [SIZE_W-1:0]   cfs_reg   = 13'd1;
  logic [SIZE_W-1:0]   sps_reg   = 13'd1;
  logic [Y_W-1:0]      sub_idx   = '0;
  logic [CNT_W-1:0]    chunk_idx = '0;
  logic [CNT_W-1:0]    byte_idx  = '0;

  byte_req_t  pending_bytes[$];
  write_req_t expected_writes[$];

  bit          gaps_on   = 1'b1;
  bit          stalls_on = 1'b1;
  int unsigned send_hold = 0;
  int unsigned recv_hold = 0;
  byte_req_t   next_byte;
  byte_req_t   taken_byte;
  write_req_t  want;

  int unsigned error_cnt       = 0;
  int unsigned bytes_checked   = 0;
  int unsigned suppressed_cnt  = 0;
  int unsigned subpackets_cnt  = 0;
  int unsigned superblocks_cnt = 0;
  int unsigned reg_writes      = 0;

  function automatic int unsigned eff_h();
    if (h_reg == '0) return 1;
    if (h_reg > H_MAX) return H_MAX;
    return h_reg;
  endfunction

  function automatic int unsigned eff_size(input logic [SIZE_W-1:0] v);
    if (v == '0) return 1;
    if (v > SIZE_MAX) return SIZE_MAX;
    return v;
  endfunction

  // Bytes in one full subpacket under the current settings (0 when empty)
  function automatic int unsigned subpacket_len();
    case (mode_reg)
      MODE_CHUNKED: return (eff_h() / 2) * eff_size(cfs_reg);
      MODE_SUBPKT:  return (eff_size(w_reg) / eff_size(sps_reg)) * eff_size(sps_reg);
      default:      return eff_size(w_reg);
    endcase
  endfunction

  // Place one byte in the superblock and advance the counters
  function automatic write_req_t locate_byte(input byte_req_t r);
    int unsigned     h, w, cfs, sps, cps, csize, y, x, b;
    longint unsigned addr, limit;
    write_req_t      o;
    h   = eff_h();
    w   = eff_size(w_reg);
    cfs = eff_size(cfs_reg);
    sps = eff_size(sps_reg);
    case (mode_reg)
      MODE_CHUNKED: begin
        cps   = h / 2;
        csize = cfs;
      end
      MODE_SUBPKT: begin
        cps   = w / sps;
        csize = sps;
      end
      default: begin
        cps   = 1;
        csize = w;
      end
    endcase
    y = sub_idx;
    x = chunk_idx;
    b = byte_idx;
    // a packet start abandons the open subpacket
    if (r.start) begin
      x = 0;
      b = 0;
      if (r.key) y = 0;
    end
    // drop counters left stale by a settings change
    if (y >= h) y = 0;
    if (x >= cps || b >= csize) begin
      x = 0;
      b = 0;
    end
    o      = '0;
    o.data = r.data;
    if (cps == 0) begin
      o.sp_done = 1'b1;
    end else begin
      case (mode_reg)
        MODE_CHUNKED: addr = 64'(x) * 2 * w + 64'(y) * cfs + b;
        MODE_SUBPKT:  addr = 64'(sps) * (64'(h) * x + 64'((h + 1) / 2) * (y & 1) + (y >> 1)) + b;
        default:      addr = 64'(y) * w + b;
      endcase
      limit = 64'(w) * h;
      if (limit > SB_LIMIT) limit = SB_LIMIT;
      o.wr_valid = (mode_reg != MODE_MUTED) && (addr < limit);
      if (o.wr_valid) o.addr = addr[ADDR_W-1:0];
      b++;
      if (b >= csize) begin
        b = 0;
        x++;
        if (x >= cps) begin
          x = 0;
          o.sp_done = 1'b1;
        end
      end
    end
    if (o.sp_done) begin
      y++;
      if (y >= h) begin
        y = 0;
        o.sb_done = 1'b1;
      end
    end
    sub_idx   = y[Y_W-1:0];
    chunk_idx = x[CNT_W-1:0];
    byte_idx  = b[CNT_W-1:0];
    return o;
  endfunction

  // Mostly no gap, some short ones, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 4);
    return $urandom_range(10, 40);
  endfunction

  // Mostly small sizes, sometimes zero, the maximum or beyond it
  function automatic logic [SIZE_W-1:0] pick_size(input int unsigned hi);
    case ($urandom_range(0, 19))
      17:      return '0;
      18:      return SIZE_MAX;
      19:      return SIZE_W'($urandom_range(0, 8191));
      default: return SIZE_W'($urandom_range(1, hi));
    endcase
  endfunction

  function automatic void queue_byte(input logic [DATA_W-1:0] d, input logic s, input logic k);
    byte_req_t r;
    r.data  = d;
    r.start = s;
    r.key   = k;
    pending_bytes.push_back(r);
  endfunction

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s expected %0h got %0h", $time, name, exp_v, act_v);
      error_cnt++;
    end
  endtask

  // Hold until every queued byte is taken and every write request is back
  task automatic drain();
    do @(negedge clk);
    while (pending_bytes.size() != 0 || in_ch.valid || expected_writes.size() != 0);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.wdata <= val;
    do @(posedge clk);
    while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      REG_INTERLEAVE_MODE:      mode_reg = mode_t'(val[MODE_W-1:0]);
      REG_SUBPACKETS_PER_BLOCK: h_reg    = val[H_W-1:0];
      REG_FRAME_BYTES:          w_reg    = val[SIZE_W-1:0];
      REG_CODED_FRAME_BYTES:    cfs_reg  = val[SIZE_W-1:0];
      REG_CHUNK_BYTES:          sps_reg  = val[SIZE_W-1:0];
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
  endtask

  // Driver: present queued bytes, predict each one as it is taken
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      send_hold = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        taken_byte.data  = in_ch.data_byte;
        taken_byte.start = in_ch.packet_start;
        taken_byte.key   = in_ch.key_flag;
        expected_writes.push_back(locate_byte(taken_byte));
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (send_hold != 0) begin
          send_hold--;
          in_ch.valid <= 1'b0;
        end else if (pending_bytes.size() != 0) begin
          next_byte = pending_bytes.pop_front();
          in_ch.data_byte    <= next_byte.data;
          in_ch.packet_start <= next_byte.start;
          in_ch.key_flag     <= next_byte.key;
          in_ch.valid        <= 1'b1;
          send_hold = gaps_on ? pick_gap() : 0;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each write request with the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      recv_hold = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_writes.size() == 0) begin
          $display("%0t: write request with nothing expected, address %0h data %0h",
                   $time, out_ch.write_address, out_ch.write_data);
          error_cnt++;
        end else begin
          want = expected_writes.pop_front();
          check_field("write_address", want.addr, out_ch.write_address);
          check_field("write_data", want.data, out_ch.write_data);
          check_field("write_valid", want.wr_valid, out_ch.write_valid);
          check_field("subpacket_done", want.sp_done, out_ch.subpacket_done);
          check_field("superblock_done", want.sb_done, out_ch.superblock_done);
          bytes_checked++;
          if (!want.wr_valid) suppressed_cnt++;
          if (want.sp_done) subpackets_cnt++;
          if (want.sb_done) superblocks_cnt++;
        end
      end
      if (recv_hold != 0) begin
        recv_hold--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        recv_hold = stalls_on ? pick_gap() : 0;
      end
    end
  end

  initial begin
    int unsigned random_bytes, budget, queued, len, burst;
    logic [CFG_DATA_W-1:0] val;
    in_ch.valid        = 1'b0;
    in_ch.data_byte    = '0;
    in_ch.packet_start = 1'b0;
    in_ch.key_flag     = 1'b0;
    out_ch.ready       = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = REG_INTERLEAVE_MODE;
    cfg_ch.wdata       = '0;
    random_bytes = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset settings: one subpacket per block gives empty subpackets
    queue_byte(8'h00, 1'b1, 1'b1);
    queue_byte(8'hFF, 1'b0, 1'b0);

    // Largest sizes: chunk addresses cross the buffer cap after eight bytes
    drain();
    write_reg(REG_INTERLEAVE_MODE, 13'd0);
    write_reg(REG_SUBPACKETS_PER_BLOCK, 13'd64);
    write_reg(REG_FRAME_BYTES, 13'd4096);
    write_reg(REG_CODED_FRAME_BYTES, 13'd1);
    write_reg(REG_CHUNK_BYTES, 13'h1FFF);
    for (int i = 0; i < 9; i++) queue_byte(8'(i * 37), i == 0, i == 0);

    // Muted mode, key without start, start without key
    drain();
    write_reg(REG_INTERLEAVE_MODE, 13'h1FFF);
    write_reg(REG_SUBPACKETS_PER_BLOCK, 13'd2);
    write_reg(REG_FRAME_BYTES, 13'd2);
    queue_byte(8'hA5, 1'b1, 1'b1);
    queue_byte(8'h5A, 1'b0, 1'b1);
    queue_byte(8'h3C, 1'b1, 1'b0);
    queue_byte(8'hC3, 1'b0, 1'b0);

    // Out-of-range registers: zero frame, oversize block count and chunk
    drain();
    write_reg(REG_INTERLEAVE_MODE, 13'd1);
    write_reg(REG_SUBPACKETS_PER_BLOCK, 13'd127);
    write_reg(REG_FRAME_BYTES, 13'd0);
    queue_byte(8'h81, 1'b1, 1'b0);
    queue_byte(8'h7E, 1'b0, 1'b1);

    // Whole frames: one full superblock of three subpackets
    drain();
    write_reg(REG_INTERLEAVE_MODE, 13'd2);
    write_reg(REG_SUBPACKETS_PER_BLOCK, 13'd3);
    write_reg(REG_FRAME_BYTES, 13'd2);
    for (int i = 0; i < 6; i++) queue_byte(8'($urandom_range(0, 255)), i == 0, i == 0);

    // Random settings, each followed by packets that are mostly well formed
    while (random_bytes < RAND_BYTES) begin
      drain();
      case ($urandom_range(0, 9))
        0, 1, 2: val = 13'(MODE_CHUNKED);
        3, 4, 5: val = 13'(MODE_SUBPKT);
        6, 7, 8: val = 13'(MODE_WHOLE);
        default: val = 13'(MODE_MUTED);
      endcase
      if ($urandom_range(0, 3) == 0)
        val[CFG_DATA_W-1:MODE_W] = (CFG_DATA_W - MODE_W)'($urandom());
      write_reg(REG_INTERLEAVE_MODE, val);
      case ($urandom_range(0, 19))
        17:      val = '0;
        18:      val = 13'(H_MAX);
        19:      val = CFG_DATA_W'($urandom_range(0, 8191));
        default: val = CFG_DATA_W'($urandom_range(1, 8));
      endcase
      write_reg(REG_SUBPACKETS_PER_BLOCK, val);
      write_reg(REG_FRAME_BYTES, pick_size(24));
      write_reg(REG_CODED_FRAME_BYTES, pick_size(12));
      write_reg(REG_CHUNK_BYTES, pick_size(12));
      gaps_on   = $urandom_range(0, 3) != 0;
      stalls_on = $urandom_range(0, 3) != 0;
      budget = $urandom_range(25, 60);
      queued = 0;
      while (queued < budget) begin
        len = subpacket_len();
        if (len == 0) len = 1;
        if (len > MAX_BURST) len = $urandom_range(1, MAX_BURST);
        if ($urandom_range(0, 4) != 0) begin
          // well-formed packet; key on non-first bytes must be ignored
          for (int i = 0; i < len; i++)
            queue_byte(8'($urandom_range(0, 255)), i == 0,
                       (i == 0) ? ($urandom_range(0, 3) == 0) : 1'($urandom_range(0, 1)));
          queued += len;
        end else begin
          // broken packet: random length, starts and keys anywhere
          burst = $urandom_range(1, len);
          for (int i = 0; i < burst; i++)
            queue_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0,
                       1'($urandom_range(0, 1)));
          queued += burst;
        end
      end
      random_bytes += queued;
    end

    drain();
    repeat (TAIL_CYC) @(posedge clk);
    $display("checked %0d bytes over %0d register writes: %0d suppressed,", bytes_checked,
             reg_writes, suppressed_cnt);
    $display("%0d subpackets and %0d superblocks completed", subpackets_cnt, superblocks_cnt);
    if (error_cnt == 0) begin
      $display("audio_superblock_deinterleave_addr_tb: clean");
    end else begin
      $display("audio_superblock_deinterleave_addr_tb: errors");
    end
    $finish;
  end

  // Watchdog: stop a hung run
  initial begin
    #4000000;
    $display("audio_superblock_deinterleave_addr_tb: errors");
    $finish;
  end

endmodule

@@ sim.f @@
design/asbd_pkg.sv
design/asbd_if.sv
design/asbd_mul.sv
design/asbd_div.sv
design/audio_superblock_deinterleave_addr.sv
tb/sv/audio_superblock_deinterleave_addr_tb.sv
